// ===== src/bfc_pkg.sv =====
package bfc_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;

	localparam int CFG_REGS  = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 64;
	localparam int ELEM_W    = 32;

	// identity matrix in Q16.16
	localparam logic [CFG_W-1:0] CFG_RESET [CFG_REGS] = '{
		64'd65536, 64'd0, 64'd281474976710656, 64'd0,
		64'd0, 64'd65536, 64'd0, 64'd281474976710656
	};

	typedef struct packed {
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
		logic signed [31:0] box_max_z;
	} in_t;

	typedef struct packed {
		logic fully_inside;
		logic touches_clip_box;
		logic divide_fault;
	} out_t;

	typedef struct packed {
		logic fault;
		logic ok;
	} div_res_t;

	// width of a transformed homogeneous coordinate
	function automatic int sum_width(input int cw, input int fb);
		int sw;
		begin
			sw = ELEM_W + cw - fb;
			if (sw < ELEM_W) begin
				sw = ELEM_W;
			end
			return sw + 2;
		end
	endfunction

endpackage

// ===== src/box_frustum_classifier.sv =====
// Pipeline: five register stages; a request taken into stage 1 goes through stages 2
// to 5 to out_data and waits while out_stall holds. Throughput: one box per cycle
// while out_stall is low; each stage moves when the next is free. There are 24 32x32
// multipliers (one per matrix element and box bound) and 24 divide checks in parallel.
// in_stall rises only when stage 1 holds a request that cannot move on.
// Reset: pipeline empties and the matrix registers return to identity.
module box_frustum_classifier #(
	parameter int COORD_WIDTH = bfc_pkg::COORD_WIDTH,
	parameter int FRAC_BITS   = bfc_pkg::FRAC_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bfc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bfc_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  bfc_pkg::in_t                     in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output bfc_pkg::out_t                    out_data
);

	localparam int EW  = bfc_pkg::ELEM_W;
	localparam int PW  = EW + COORD_WIDTH;
	localparam int SPW = PW - FRAC_BITS;
	localparam int TW  = bfc_pkg::sum_width(COORD_WIDTH, FRAC_BITS);

	logic [bfc_pkg::CFG_W-1:0] cfg_q [bfc_pkg::CFG_REGS];

	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	logic signed [COORD_WIDTH-1:0] lo_s1 [3];
	logic signed [COORD_WIDTH-1:0] hi_s1 [3];
	logic signed [SPW-1:0]         plo_s2 [4][3];
	logic signed [SPW-1:0]         phi_s2 [4][3];
	logic signed [TW-1:0]          t_s3 [8][4];
	logic [TW-1:0]                 an_s4 [8][3];
	logic [TW-1:0]                 aw_s4 [8];
	logic                          neg_s4 [8][3];
	logic signed [TW-1:0]          bmin_s4 [3];
	logic signed [TW-1:0]          bmax_s4 [3];

	logic signed [EW-1:0]  elem [4][4];
	logic signed [SPW-1:0] plo_d [4][3];
	logic signed [SPW-1:0] phi_d [4][3];
	logic signed [TW-1:0]  t_d [8][4];
	logic signed [TW-1:0]  bmin_d [3];
	logic signed [TW-1:0]  bmax_d [3];
	bfc_pkg::div_res_t     dres [8][3];
	bfc_pkg::out_t         res_d;
	bfc_pkg::out_t         res_s5;

	assign rdy5     = !v5_s5 || !out_stall;
	assign rdy4     = !v4_s4 || rdy5;
	assign rdy3     = !v3_s3 || rdy4;
	assign rdy2     = !v2_s2 || rdy3;
	assign rdy1     = !v1_s1 || rdy2;
	assign in_stall = !rdy1;
	assign out_valid = v5_s5;
	assign out_data  = res_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bfc_pkg::CFG_REGS; i++) begin
				cfg_q[i] <= bfc_pkg::CFG_RESET[i];
			end
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_wdata;
		end
	end

	// matrix element (r, c) lives in register 2r + c/2, half c%2
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				elem[r][c] = cfg_q[2*r + c/2][EW*(c%2) +: EW];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= in_valid;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) v3_s3 <= v2_s2;
			if (rdy4) v4_s4 <= v3_s3;
			if (rdy5) v5_s5 <= v4_s4;
		end
	end

	// stage 1: capture coordinates
	always_ff @(posedge clk) begin
		if (rdy1) begin
			lo_s1[0] <= in_data.box_min_x[COORD_WIDTH-1:0];
			lo_s1[1] <= in_data.box_min_y[COORD_WIDTH-1:0];
			lo_s1[2] <= in_data.box_min_z[COORD_WIDTH-1:0];
			hi_s1[0] <= in_data.box_max_x[COORD_WIDTH-1:0];
			hi_s1[1] <= in_data.box_max_y[COORD_WIDTH-1:0];
			hi_s1[2] <= in_data.box_max_z[COORD_WIDTH-1:0];
		end
	end

	// stage 2: products, floored by dropping the fraction bits
	always_comb begin
		logic signed [PW-1:0] m;
		logic signed [PW-1:0] pl;
		logic signed [PW-1:0] ph;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 3; c++) begin
				m  = PW'(elem[r][c]);
				pl = m * PW'(lo_s1[c]);
				ph = m * PW'(hi_s1[c]);
				plo_d[r][c] = pl[PW-1:FRAC_BITS];
				phi_d[r][c] = ph[PW-1:FRAC_BITS];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			plo_s2 <= plo_d;
			phi_s2 <= phi_d;
		end
	end

	// stage 3: corner i takes max along axis c when bit c of i is set
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			for (int r = 0; r < 4; r++) begin
				t_d[i][r] = TW'(elem[r][3]);
				for (int c = 0; c < 3; c++) begin
					t_d[i][r] = t_d[i][r] + (((i >> c) & 1) != 0 ?
						TW'(phi_s2[r][c]) : TW'(plo_s2[r][c]));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			t_s3 <= t_d;
		end
	end

	// stage 4: magnitudes, quotient signs, undivided bounding box
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			bmin_d[c] = t_s3[0][c];
			bmax_d[c] = t_s3[0][c];
			for (int i = 1; i < 8; i++) begin
				if (t_s3[i][c] < bmin_d[c]) bmin_d[c] = t_s3[i][c];
				if (t_s3[i][c] > bmax_d[c]) bmax_d[c] = t_s3[i][c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			for (int i = 0; i < 8; i++) begin
				aw_s4[i] <= t_s3[i][3][TW-1] ? TW'(-t_s3[i][3]) : TW'(t_s3[i][3]);
				for (int c = 0; c < 3; c++) begin
					an_s4[i][c]  <= t_s3[i][c][TW-1] ? TW'(-t_s3[i][c]) : TW'(t_s3[i][c]);
					neg_s4[i][c] <= t_s3[i][c][TW-1] != t_s3[i][3][TW-1];
				end
			end
			bmin_s4 <= bmin_d;
			bmax_s4 <= bmax_d;
		end
	end

	// stage 5: divide checks and overlap test
	for (genvar gi = 0; gi < 8; gi++) begin : g_corner
		for (genvar gc = 0; gc < 3; gc++) begin : g_axis
			bfc_div_check #(
				.COORD_WIDTH(COORD_WIDTH),
				.FRAC_BITS  (FRAC_BITS)
			) u_div (
				.an  (an_s4[gi][gc]),
				.aw  (aw_s4[gi]),
				.neg (neg_s4[gi][gc]),
				.is_z(gc == 2),
				.res (dres[gi][gc])
			);
		end
	end

	always_comb begin
		logic signed [TW-1:0] one;
		logic signed [TW-1:0] lower;
		one   = TW'(1) <<< FRAC_BITS;
		res_d = '{fully_inside: 1'b1, touches_clip_box: 1'b1, divide_fault: 1'b0};
		for (int i = 0; i < 8; i++) begin
			for (int c = 0; c < 3; c++) begin
				if (!dres[i][c].ok) res_d.fully_inside = 1'b0;
				if (dres[i][c].fault) res_d.divide_fault = 1'b1;
			end
		end
		for (int c = 0; c < 3; c++) begin
			lower = (c == 2) ? '0 : -one;
			if (bmax_s4[c] < lower || one < bmin_s4[c]) res_d.touches_clip_box = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			res_s5 <= res_d;
		end
	end

endmodule

// ===== src/bfc_div_check.sv =====
module bfc_div_check #(
	parameter int COORD_WIDTH = bfc_pkg::COORD_WIDTH,
	parameter int FRAC_BITS   = bfc_pkg::FRAC_BITS
) (
	input  logic [bfc_pkg::sum_width(COORD_WIDTH, FRAC_BITS)-1:0] an,
	input  logic [bfc_pkg::sum_width(COORD_WIDTH, FRAC_BITS)-1:0] aw,
	input  logic                                                  neg,
	input  logic                                                  is_z,
	output bfc_pkg::div_res_t                                     res
);

	localparam int TW   = bfc_pkg::sum_width(COORD_WIDTH, FRAC_BITS);
	localparam int CMPW = TW + FRAC_BITS + COORD_WIDTH + 1;

	logic [CMPW-1:0] a_sh;
	logic [CMPW-1:0] w_ext;
	logic [CMPW-1:0] w_sh;
	logic [CMPW-1:0] lim_b;
	logic [CMPW-1:0] one_b;

	// quotient q = floor(an * 2^F / aw) is bounded by comparing an * 2^F against aw * (k + 1)
	always_comb begin
		a_sh  = CMPW'(an) << FRAC_BITS;
		w_ext = CMPW'(aw);
		w_sh  = w_ext << FRAC_BITS;
		lim_b = (w_ext << (COORD_WIDTH - 1)) + (neg ? w_ext : '0);
		one_b = w_sh + w_ext;
		res.fault = (aw == '0) || !(a_sh < lim_b);
		if (is_z && neg) begin
			res.ok = !res.fault && (a_sh < w_ext);
		end else begin
			res.ok = !res.fault && (a_sh < one_b);
		end
	end

endmodule
